@@ rtl/tvce_pkg.sv @@
// Shared types, constants and helpers of the turtle vector command engine.
// Depends on nothing; every module imports it.
package tvce_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_W      = 16;
  localparam int Q            = 30;
  localparam int TRIG_W       = 34;
  localparam int MUL_A_W      = 17;
  localparam int PROD_W       = MUL_A_W + TRIG_W;
  localparam int ACC_W        = ((COORD_W + Q > PROD_W) ? COORD_W + Q : PROD_W) + 3;
  localparam int CNT_W        = $clog2(CORDIC_STEPS + 1);
  localparam int TURN_MAG_W   = 23;
  localparam int RECIP_W      = 25;
  localparam int BAM_PROD_W   = TURN_MAG_W + RECIP_W;
  localparam int RECIP_SHIFT  = 30;

  localparam logic [TRIG_W-1:0]  CORDIC_GAIN = TRIG_W'(652032874);
  // ceil(2^30 / 45): exact floor division for every turn magnitude
  localparam logic [RECIP_W-1:0] RECIP_45    = RECIP_W'(23860930);
  localparam logic [TURN_MAG_W-1:0] TURN_BIAS = TURN_MAG_W'(22);

  localparam logic [2:0] CMD_FWD  = 3'd0;
  localparam logic [2:0] CMD_ROT  = 3'd1;
  localparam logic [2:0] CMD_PUP  = 3'd2;
  localparam logic [2:0] CMD_PDN  = 3'd3;
  localparam logic [2:0] CMD_COL  = 3'd4;
  localparam logic [2:0] CMD_CIRC = 3'd5;
  localparam logic [2:0] CMD_ARC  = 3'd6;

  localparam logic [1:0] SHAPE_LINE   = 2'd0;
  localparam logic [1:0] SHAPE_CIRCLE = 2'd1;
  localparam logic [1:0] SHAPE_ARC    = 2'd2;

  typedef enum logic [2:0] {
    OP_FWD, OP_ROT, OP_PUP, OP_PDN, OP_COL, OP_CIRC, OP_ARC
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic signed [15:0]     distance;
    logic [14:0]            radius;
    logic signed [17:0]     turn;
    logic [23:0]            color;
    logic                   turn_neg;
    logic [TURN_MAG_W-1:0]  turn_mag;
  } tvce_item_t;

  typedef struct packed {
    logic                   valid;
    tvce_item_t             item;
  } tvce_queue_t;

  localparam logic signed [ACC_W-1:0] Q_BIAS    = (ACC_W'(1) << Q) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] COORD_MAX = (ACC_W'(1) << (COORD_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] COORD_MIN = -COORD_MAX - ACC_W'(1);

  function automatic logic [TRIG_W-1:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return TRIG_W'(v);
  endfunction

  // Q30 value to pixel: truncate toward zero, then saturate
  function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] t;
    b = v + (v[ACC_W-1] ? Q_BIAS : '0);
    t = b >>> Q;
    if (t > COORD_MAX) begin
      t = COORD_MAX;
    end else if (t < COORD_MIN) begin
      t = COORD_MIN;
    end
    return t[COORD_W-1:0];
  endfunction

endpackage

@@ rtl/tvce_front.sv @@
// Front end: accepts command items, drops unknown codes, classifies and
// precomputes the turn magnitude, and holds them in a two-entry queue. Uses tvce_pkg.
module tvce_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            cmd,
  input  logic signed [15:0]    distance,
  input  logic [14:0]           radius,
  input  logic signed [17:0]    turn_degrees,
  input  logic [23:0]           new_color,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  output tvce_pkg::tvce_queue_t q_head,
  input  logic                  q_pop
);
  import tvce_pkg::*;

  tvce_item_t q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  tvce_item_t entry;
  logic       known;
  logic [17:0] mag;
  logic       push;
  logic       pop;

  always_comb begin
    known = 1'b1;
    entry.op = OP_FWD;
    unique case (cmd)
      CMD_FWD:  entry.op = OP_FWD;
      CMD_ROT:  entry.op = OP_ROT;
      CMD_PUP:  entry.op = OP_PUP;
      CMD_PDN:  entry.op = OP_PDN;
      CMD_COL:  entry.op = OP_COL;
      CMD_CIRC: entry.op = OP_CIRC;
      CMD_ARC:  entry.op = OP_ARC;
      default:  known = 1'b0;
    endcase
    mag = turn_degrees[17] ? 18'(-turn_degrees) : 18'(turn_degrees);
    entry.distance = distance;
    entry.radius   = radius;
    entry.turn     = turn_degrees;
    entry.color    = new_color;
    entry.turn_neg = turn_degrees[17];
    entry.turn_mag = {mag, 5'b0} + TURN_BIAS;
  end

  assign cmd_ready    = (count != 2'd2);
  // drop unknown codes at the door
  assign push         = cmd_valid && cmd_ready && known;
  assign pop          = q_pop && (count != 2'd0);
  assign q_head.valid = (count != 2'd0);
  assign q_head.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/tvce_cordic.sv @@
// Iterative CORDIC rotation: cosine and sine of a 16-bit binary angle in Q30,
// one step a cycle. Uses tvce_pkg.
module tvce_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [15:0]                       angle,
  output logic                              done,
  output logic signed [tvce_pkg::TRIG_W-1:0] cos_q,
  output logic signed [tvce_pkg::TRIG_W-1:0] sin_q
);
  import tvce_pkg::*;

  logic signed [TRIG_W-1:0] x;
  logic signed [TRIG_W-1:0] y;
  logic signed [TRIG_W-1:0] z;
  logic                     flip;
  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic [31:0]              a;
  logic                     f;
  logic [31:0]              a2;
  logic signed [TRIG_W-1:0] xs;
  logic signed [TRIG_W-1:0] ys;
  logic signed [TRIG_W-1:0] at;

  always_comb begin
    a  = {angle, 16'b0};
    // second and third quadrants fold by half a turn
    f  = a[31] ^ a[30];
    a2 = f ? {~a[31], a[30:0]} : a;
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = signed'(atan_entry(5'(cnt)));
  end

  assign cos_q = flip ? -x : x;
  assign sin_q = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      flip <= 1'b0;
      x    <= '0;
      y    <= '0;
      z    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= signed'(CORDIC_GAIN);
        y    <= '0;
        z    <= TRIG_W'(signed'(a2));
        flip <= f;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!z[TRIG_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/tvce_back.sv @@
// Back end: turtle state and command sequencer, sharing one CORDIC unit,
// with the result register. Uses tvce_pkg and tvce_cordic.
module tvce_back (
  input  logic                              clk,
  input  logic                              rst,
  input  tvce_pkg::tvce_queue_t             q_head,
  output logic                              q_pop,
  output logic [1:0]                        shape_kind,
  output logic signed [tvce_pkg::COORD_W-1:0] first_x,
  output logic signed [tvce_pkg::COORD_W-1:0] first_y,
  output logic signed [tvce_pkg::COORD_W-1:0] end_x,
  output logic signed [tvce_pkg::COORD_W-1:0] end_y,
  output logic [14:0]                       shape_radius,
  output logic [16:0]                       start_angle,
  output logic signed [18:0]                end_angle,
  output logic [23:0]                       shape_color,
  output logic                              shape_valid,
  input  logic                              shape_ready
);
  import tvce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ROT, S_TRIG1, S_MUL1, S_SUM1, S_EMIT,
    S_TRIG2, S_MUL2, S_SUM2, S_FIN
  } state_t;

  state_t                    state;
  tvce_item_t                it;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [15:0]               heading;
  logic                      pen;
  logic [23:0]               colour;
  logic [BAM_PROD_W-1:0]     bam_prod;
  logic signed [PROD_W-1:0]  prod_a;
  logic signed [PROD_W-1:0]  prod_b;
  logic signed [ACC_W-1:0]   acc_x;
  logic signed [ACC_W-1:0]   acc_y;
  logic                      cord_start;
  logic [15:0]               cord_angle;
  logic                      cord_done;
  logic signed [TRIG_W-1:0]  trig_c;
  logic signed [TRIG_W-1:0]  trig_s;

  logic [17:0]               bam_q;
  logic [15:0]               bam;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [ACC_W-1:0]   pos_x_ext;
  logic signed [ACC_W-1:0]   pos_y_ext;
  logic signed [ACC_W-1:0]   pa_ext;
  logic signed [ACC_W-1:0]   pb_ext;
  logic signed [COORD_W-1:0] nx;
  logic signed [COORD_W-1:0] ny;
  logic [21:0]               st_full;
  logic [16:0]               st;
  logic                      out_free;

  tvce_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (cord_angle),
    .done  (cord_done),
    .cos_q (trig_c),
    .sin_q (trig_s)
  );

  always_comb begin
    bam_q     = bam_prod[RECIP_SHIFT +: 18];
    bam       = it.turn_neg ? 16'(-bam_q) : bam_q[15:0];
    mul_a     = (it.op == OP_FWD) ? MUL_A_W'(it.distance) : MUL_A_W'({2'b0, it.radius});
    pos_x_ext = {{(ACC_W-COORD_W-Q){pos_x[COORD_W-1]}}, pos_x, {Q{1'b0}}};
    pos_y_ext = {{(ACC_W-COORD_W-Q){pos_y[COORD_W-1]}}, pos_y, {Q{1'b0}}};
    pa_ext    = ACC_W'(prod_a);
    pb_ext    = ACC_W'(prod_b);
    nx        = to_coord(acc_x);
    ny        = to_coord(acc_y);
    st_full   = {6'b0, heading} * 22'd45 + 22'd16;
    st        = st_full[21:5];
    out_free  = !shape_valid || shape_ready;
  end

  assign q_pop = (state == S_IDLE) && q_head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos_x       <= '0;
      pos_y       <= '0;
      heading     <= '0;
      pen         <= 1'b0;
      colour      <= '0;
      shape_valid <= 1'b0;
      cord_start  <= 1'b0;
    end else begin
      cord_start <= 1'b0;
      if (shape_valid && shape_ready) begin
        shape_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_head.valid) begin
            it    <= q_head.item;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          bam_prod <= it.turn_mag * RECIP_45;
          unique case (it.op)
            OP_FWD, OP_CIRC, OP_ARC: begin
              cord_start <= 1'b1;
              cord_angle <= heading;
              state      <= S_TRIG1;
            end
            OP_ROT: state <= S_ROT;
            OP_PUP: begin
              pen   <= 1'b0;
              state <= S_IDLE;
            end
            OP_PDN: begin
              pen   <= 1'b1;
              state <= S_IDLE;
            end
            OP_COL: begin
              colour <= it.color;
              state  <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_ROT: begin
          heading <= heading + bam;
          state   <= S_IDLE;
        end
        S_TRIG1: begin
          if (cord_done) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod_a <= mul_a * trig_c;
          prod_b <= mul_a * trig_s;
          state  <= S_SUM1;
        end
        S_SUM1: begin
          if (it.op == OP_FWD) begin
            acc_x <= pos_x_ext + pa_ext;
            acc_y <= pos_y_ext + pb_ext;
          end else begin
            acc_x <= pos_x_ext - pb_ext;
            acc_y <= pos_y_ext + pa_ext;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          // hold while a drawn shape cannot leave yet
          if (!pen || out_free) begin
            if (pen) begin
              shape_valid  <= 1'b1;
              shape_color  <= colour;
              end_x        <= '0;
              end_y        <= '0;
              shape_radius <= it.radius;
              start_angle  <= '0;
              end_angle    <= '0;
              first_x      <= nx;
              first_y      <= ny;
              unique case (it.op)
                OP_FWD: begin
                  shape_kind   <= SHAPE_LINE;
                  first_x      <= pos_x;
                  first_y      <= pos_y;
                  end_x        <= nx;
                  end_y        <= ny;
                  shape_radius <= '0;
                end
                OP_ARC: begin
                  shape_kind  <= SHAPE_ARC;
                  start_angle <= st;
                  end_angle   <= {2'b0, st} + {it.turn[17], it.turn};
                end
                default: shape_kind <= SHAPE_CIRCLE;
              endcase
            end
            unique case (it.op)
              OP_FWD: begin
                pos_x <= nx;
                pos_y <= ny;
                state <= S_IDLE;
              end
              OP_ARC: begin
                cord_start <= 1'b1;
                cord_angle <= heading + bam;
                state      <= S_TRIG2;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TRIG2: begin
          if (cord_done) begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          prod_a <= mul_a * trig_c;
          prod_b <= mul_a * trig_s;
          state  <= S_SUM2;
        end
        S_SUM2: begin
          acc_x <= acc_x + pb_ext;
          acc_y <= acc_y - pa_ext;
          state <= S_FIN;
        end
        S_FIN: begin
          pos_x   <= nx;
          pos_y   <= ny;
          heading <= cord_angle;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/turtle_vector_command_engine_unit.sv @@
// Turtle vector command engine: a queueing front end and an executing back end.
// Pen and colour act in the decode state, rotate in its own; a drawn line, circle or
// arc appears after a 16-step CORDIC loop, multiply and sum, an arc move ending after
// a second such round. A drawn shape that cannot leave holds the back end. Throughput:
// one item at a time in the back end, next taken the cycle after it finishes.
// Synchronous reset: position, heading zero, pen up, colour black, all empty.
module turtle_vector_command_engine_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [2:0]                        cmd,
  input  logic signed [15:0]                distance,
  input  logic [14:0]                       radius,
  input  logic signed [17:0]                turn_degrees,
  input  logic [23:0]                       new_color,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  output logic [1:0]                        shape_kind,
  output logic signed [tvce_pkg::COORD_W-1:0] first_x,
  output logic signed [tvce_pkg::COORD_W-1:0] first_y,
  output logic signed [tvce_pkg::COORD_W-1:0] end_x,
  output logic signed [tvce_pkg::COORD_W-1:0] end_y,
  output logic [14:0]                       shape_radius,
  output logic [16:0]                       start_angle,
  output logic signed [18:0]                end_angle,
  output logic [23:0]                       shape_color,
  output logic                              shape_valid,
  input  logic                              shape_ready
);
  import tvce_pkg::*;

  tvce_queue_t q_head;
  logic        q_pop;

  tvce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .distance     (distance),
    .radius       (radius),
    .turn_degrees (turn_degrees),
    .new_color    (new_color),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  tvce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .shape_kind   (shape_kind),
    .first_x      (first_x),
    .first_y      (first_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .shape_radius (shape_radius),
    .start_angle  (start_angle),
    .end_angle    (end_angle),
    .shape_color  (shape_color),
    .shape_valid  (shape_valid),
    .shape_ready  (shape_ready)
  );

  a_line_fields: assert property (@(posedge clk) disable iff (rst)
    shape_valid && shape_kind == SHAPE_LINE |->
      shape_radius == '0 && start_angle == '0 && end_angle == '0)
    else $error("line item carries radius or angles");

  a_round_fields: assert property (@(posedge clk) disable iff (rst)
    shape_valid && shape_kind != SHAPE_LINE |-> end_x == '0 && end_y == '0)
    else $error("circle or arc item carries an end point");

  a_circle_angles: assert property (@(posedge clk) disable iff (rst)
    shape_valid && shape_kind == SHAPE_CIRCLE |-> start_angle == '0 && end_angle == '0)
    else $error("circle item carries angles");

endmodule

@@ verif/tvce_checker.sv @@
// Checker for the turtle vector command engine: watches both channels,
// predicts shapes from a turtle state model and compares them. Needs tvce_pkg.
module tvce_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         cmd,
  input  logic signed [15:0] distance,
  input  logic [14:0]        radius,
  input  logic signed [17:0] turn_degrees,
  input  logic [23:0]        new_color,
  input  logic               cmd_valid,
  input  logic               cmd_ready,
  input  logic [1:0]         shape_kind,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic [14:0]        shape_radius,
  input  logic [16:0]        start_angle,
  input  logic signed [18:0] end_angle,
  input  logic [23:0]        shape_color,
  input  logic               shape_valid,
  input  logic               shape_ready,
  output int                 fail_count,
  output int                 pending_shapes
);
  import tvce_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [14:0]        rad;
    logic [16:0]        sa;
    logic signed [18:0] ea;
    logic [23:0]        col;
  } shape_t;

  shape_t shape_q[$];
  longint turtle_x, turtle_y;
  logic [15:0] turtle_hd;
  logic turtle_pen;
  logic [23:0] turtle_col;

  function automatic longint floor_shift(longint v, int s);
    if (v < 0) return -(((-v) - 1) >>> s) - 1;
    return v >>> s;
  endfunction

  task automatic cordic_sincos(input logic [15:0] bam, output longint c, output longint s);
    logic [31:0] a;
    logic flip;
    longint x, y, z, nx;
    longint angles[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    a = {bam, 16'h0};
    flip = 0;
    x = 652032874;
    y = 0;
    if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      a = a - 32'h8000_0000;
      flip = 1;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= angles[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += angles[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint pixel_of(longint q);
    longint v;
    v = (q < 0) ? -((-q) >>> 30) : (q >>> 30);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [15:0] turn_as_bam(longint t);
    longint n, q;
    n = t * 32;
    q = ((n < 0 ? -n : n) + 22) / 45;
    if (n < 0) q = -q;
    return q[15:0];
  endfunction

  task automatic predict_shape(input logic [2:0] c_in, input longint step_len,
                               input longint rad, input longint turn,
                               input logic [23:0] col);
    longint c, s, c2, s2, cx, cy, nx, ny, st;
    logic [15:0] h2;
    shape_t e;
    e = '0;
    e.col = turtle_col;
    case (c_in)
      CMD_FWD: begin
        cordic_sincos(turtle_hd, c, s);
        nx = pixel_of(turtle_x * (64'sd1 << 30) + step_len * c);
        ny = pixel_of(turtle_y * (64'sd1 << 30) + step_len * s);
        if (turtle_pen) begin
          e.kind = SHAPE_LINE;
          e.fx = turtle_x[15:0];
          e.fy = turtle_y[15:0];
          e.ex = nx[15:0];
          e.ey = ny[15:0];
          shape_q.push_back(e);
        end
        turtle_x = nx;
        turtle_y = ny;
      end
      CMD_ROT: turtle_hd = turtle_hd + turn_as_bam(turn);
      CMD_PUP: turtle_pen = 0;
      CMD_PDN: turtle_pen = 1;
      CMD_COL: turtle_col = col;
      CMD_CIRC, CMD_ARC: begin
        cordic_sincos(turtle_hd, c, s);
        cx = turtle_x * (64'sd1 << 30) - rad * s;
        cy = turtle_y * (64'sd1 << 30) + rad * c;
        if (turtle_pen) begin
          st = (longint'(turtle_hd) * 45 + 16) >>> 5;
          e.kind = (c_in == CMD_CIRC) ? SHAPE_CIRCLE : SHAPE_ARC;
          nx = pixel_of(cx);
          ny = pixel_of(cy);
          e.fx = nx[15:0];
          e.fy = ny[15:0];
          e.rad = rad[14:0];
          if (c_in == CMD_ARC) begin
            e.sa = st[16:0];
            nx = st + turn;
            e.ea = nx[18:0];
          end
          shape_q.push_back(e);
        end
        if (c_in == CMD_ARC) begin
          h2 = turtle_hd + turn_as_bam(turn);
          cordic_sincos(h2, c2, s2);
          turtle_x = pixel_of(cx + rad * s2);
          turtle_y = pixel_of(cy - rad * c2);
          turtle_hd = h2;
        end
      end
      default: ;
    endcase
  endtask

  assign pending_shapes = shape_q.size();

  always @(posedge clk) begin
    shape_t got, want;
    if (rst) begin
      turtle_x <= 0;
      turtle_y <= 0;
      turtle_hd <= '0;
      turtle_pen <= 0;
      turtle_col <= '0;
      fail_count <= 0;
      shape_q.delete();
    end else begin
      if (shape_valid && shape_ready) begin
        got = '{shape_kind, first_x, first_y, end_x, end_y, shape_radius,
                start_angle, end_angle, shape_color};
        if (shape_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected shape %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = shape_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("shape mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      // the model state is only touched here, so blocking updates are safe
      if (cmd_valid && cmd_ready)
        predict_shape(cmd, distance, radius, turn_degrees, new_color);
    end
  end
endmodule

@@ verif/tb.sv @@
// Top of the turtle vector command engine regression: clock, reset, command
// stimulus and verdict. Depends on tvce_pkg, the engine and tvce_checker.
module tb;
  import tvce_pkg::*;

  logic clk = 0, rst = 1;
  logic [2:0] cmd = '0;
  logic signed [15:0] distance = '0;
  logic [14:0] radius = '0;
  logic signed [17:0] turn_degrees = '0;
  logic [23:0] new_color = '0;
  logic cmd_valid = 0, cmd_ready;
  logic [1:0] shape_kind;
  logic signed [15:0] first_x, first_y, end_x, end_y;
  logic [14:0] shape_radius;
  logic [16:0] start_angle;
  logic signed [18:0] end_angle;
  logic [23:0] shape_color;
  logic shape_valid, shape_ready = 0;
  int fail_count, pending_shapes;
  int cycle_count = 0;
  logic calm = 0, hold_off = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  turtle_vector_command_engine_unit dut (.*);
  tvce_checker chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("turtle_vector_command_engine_unit regression: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        shape_ready <= 0;
        repeat (300) @(posedge clk);
        // release and drain until the sender ends the hold-off
        shape_ready <= 1;
        while (hold_off) @(posedge clk);
      end else if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(11, 1);
        shape_ready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        shape_ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_cmd(input logic [2:0] c, input logic signed [15:0] d,
                          input logic [14:0] r, input logic signed [17:0] t,
                          input logic [23:0] col);
    int n;
    if (!calm && $urandom_range(4) == 0) begin
      n = $urandom_range(11, 1);
      cmd_valid <= 0;
      repeat (n) @(posedge clk);
    end
    cmd <= c;
    distance <= d;
    radius <= r;
    turn_degrees <= t;
    new_color <= col;
    cmd_valid <= 1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  task automatic random_cmd();
    logic [2:0] c;
    logic signed [17:0] t;
    logic signed [15:0] d;
    c = 3'($urandom_range(7));
    if ($urandom_range(7) == 0) c = CMD_PDN;
    t = $urandom_range(3) == 0 ? 18'($urandom) : 18'($signed($urandom_range(184320)) - 92160);
    d = $urandom_range(3) == 0 ? 16'($urandom) : 16'($signed($urandom_range(400)) - 200);
    send_cmd(c, d, $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(300)), t,
             24'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    // directed: pen-up moves, extremes, unknown code, every command
    send_cmd(CMD_FWD, 100, 0, 0, 0);
    send_cmd(CMD_CIRC, 0, 50, 0, 0);
    send_cmd(CMD_ARC, 0, 40, 23040, 0);
    send_cmd(CMD_COL, 0, 0, 0, 24'hFFFFFF);
    send_cmd(CMD_PDN, 0, 0, 0, 0);
    send_cmd(CMD_FWD, 16'sh7FFF, 0, 0, 0);
    send_cmd(CMD_FWD, 16'sh7FFF, 0, 0, 0);
    send_cmd(CMD_ROT, 0, 0, 92160, 0);
    send_cmd(CMD_ROT, 0, 0, -92160, 0);
    send_cmd(CMD_ROT, 0, 0, 18'sh1FFFF, 0);
    send_cmd(CMD_ROT, 0, 0, 18'sh20000, 0);
    send_cmd(CMD_FWD, 16'sh8000, 0, 0, 0);
    send_cmd(3'd7, 16'sh7FFF, 15'h7FFF, 18'sh1FFFF, 24'hFFFFFF);
    send_cmd(CMD_CIRC, 0, 15'h7FFF, 0, 0);
    send_cmd(CMD_ARC, 0, 15'h7FFF, 18'sh20000, 0);
    send_cmd(CMD_ARC, 0, 100, 18'sh1FFFF, 0);
    send_cmd(CMD_COL, 0, 0, 0, 24'h0);
    send_cmd(CMD_ARC, 0, 0, -23040, 0);
    send_cmd(CMD_PUP, 0, 0, 0, 0);
    send_cmd(CMD_FWD, -5, 0, 0, 0);
    send_cmd(CMD_PDN, 0, 0, 0, 0);
    for (int i = 0; i < 500; i++) random_cmd();
    // fill the engine while the receiver holds off
    send_cmd(CMD_PDN, 0, 0, 0, 0);
    hold_off = 1;
    for (int i = 0; i < 20; i++) send_cmd(CMD_FWD, 16'($urandom), 0, 0, 0);
    hold_off = 0;
    cmd_valid <= 0;
    @(posedge clk);
    while (pending_shapes != 0) @(posedge clk);
    for (int i = 0; i < 450; i++) random_cmd();
    calm = 1;
    for (int i = 0; i < 100; i++) random_cmd();
    cmd_valid <= 0;
    @(posedge clk);
    while (pending_shapes != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("turtle_vector_command_engine_unit regression: pass");
    else
      $display("turtle_vector_command_engine_unit regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/tvce_pkg.sv
rtl/tvce_front.sv
rtl/tvce_cordic.sv
rtl/tvce_back.sv
rtl/turtle_vector_command_engine_unit.sv
verif/tvce_checker.sv
verif/tb.sv
